/* rtl/psf2u_pkg.sv */
// Shared types, constants and byte classification for the PSF2 unicode table parser.
package psf2u_pkg;

  localparam logic [7:0]  BYTE_GLYPH_SEP = 8'hFF;
  localparam logic [7:0]  BYTE_SEQ_SEP   = 8'hFE;
  localparam logic [7:0]  MASK_LEAD2     = 8'hE0;
  localparam logic [7:0]  MASK_LEAD3     = 8'hF0;
  localparam logic [7:0]  MASK_LEAD4     = 8'hF8;
  localparam logic [7:0]  PFX_LEAD2      = 8'hC0;
  localparam logic [7:0]  PFX_LEAD3      = 8'hE0;
  localparam logic [7:0]  PFX_LEAD4      = 8'hF0;
  localparam logic [20:0] CP_REPLACE     = 21'h00FFFD;
  localparam logic [16:0] TOTAL_RESET    = 17'd256;

  // Continuation bytes still missing in the open sequence
  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_table;
  } item_t;

  // Result item
  typedef struct packed {
    logic [20:0] code_point;
    logic [15:0] glyph_number;
    logic        run_last;
  } entry_t;

  // One decoded result before run_last is attached
  typedef struct packed {
    logic [20:0] cp;
    logic [15:0] glyph;
  } res_t;

  // Decoder state
  typedef struct packed {
    logic [2:0][7:0] hb;
    logic [1:0]      needed;
    logic [1:0]      held;
    logic [16:0]     counter;
  } st_t;

  // Outcome of one byte seen at a sequence start
  typedef struct packed {
    logic        emit;
    logic [20:0] cp;
    logic [16:0] counter;
    logic [1:0]  need;
  } start_t;

  function automatic start_t start_step(input logic [7:0]  b,
                                        input logic        fin,
                                        input logic [16:0] counter,
                                        input logic [16:0] total);
    start_t r;
    r.emit    = 1'b0;
    r.cp      = CP_REPLACE;
    r.counter = counter;
    r.need    = NEED_NONE;
    if (counter < total) begin
      if (b == BYTE_GLYPH_SEP) begin
        r.counter = counter + 17'd1;
      end else if (b != BYTE_SEQ_SEP) begin
        if (!b[7]) begin
          r.emit = 1'b1;
          r.cp   = {13'd0, b};
        end else if ((b & MASK_LEAD2) == PFX_LEAD2) begin
          r.need = NEED_ONE;
        end else if ((b & MASK_LEAD3) == PFX_LEAD3) begin
          r.need = NEED_TWO;
        end else if ((b & MASK_LEAD4) == PFX_LEAD4) begin
          r.need = NEED_THREE;
        end else begin
          r.emit = 1'b1;
        end
        // lead byte on the last byte of the table: truncated
        if (r.need != NEED_NONE && fin) begin
          r.emit = 1'b1;
          r.cp   = CP_REPLACE;
          r.need = NEED_NONE;
        end
      end
    end
    return r;
  endfunction

endpackage

/* rtl/psf2u_decode.sv */
// Per-byte UTF-8 decode step: state and byte in, up to four results and next state out.
module psf2u_decode
  import psf2u_pkg::*;
(
  input  st_t           st,
  input  logic [16:0]   glyph_total,
  input  item_t         item,
  output st_t           st_next,
  output res_t [3:0]    res,
  output logic [2:0]    res_cnt
);

  // Join lead and continuation bytes of a sequence closed by byte b
  function automatic logic [20:0] assemble(input st_t s, input logic [7:0] b);
    logic [20:0] cp;
    case (s.held)
      2'd1:    cp = {10'd0, s.hb[0][4:0], b[5:0]};
      2'd2:    cp = {5'd0, s.hb[0][3:0], s.hb[1][5:0], b[5:0]};
      2'd3:    cp = {s.hb[0][2:0], s.hb[1][5:0], s.hb[2][5:0], b[5:0]};
      default: cp = {12'd0, s.hb[0][2:0], b[5:0]};
    endcase
    return cp;
  endfunction

  start_t     s0;
  start_t     s1;
  start_t     s1b;
  start_t     s2;
  res_t [3:0] slot;
  logic [3:0] slot_v;
  logic [2:0] n;

  // Candidate start-of-sequence outcomes, including the replay chain
  always_comb begin
    s0  = start_step(item.data_byte, item.end_of_table, st.counter, glyph_total);
    s1  = start_step(st.hb[1], 1'b0, st.counter, glyph_total);
    s1b = start_step(item.data_byte, 1'b1, st.counter, glyph_total);
    s2  = start_step(item.data_byte, 1'b1, s1.counter, glyph_total);
  end

  // Select results and next state
  always_comb begin
    st_next = st;
    slot_v  = 4'd0;
    for (int i = 0; i < 4; i++) begin
      slot[i] = '{cp: CP_REPLACE, glyph: st.counter[15:0]};
    end
    case (st.needed)
      NEED_NONE: begin
        slot[0]         = '{cp: s0.cp, glyph: st.counter[15:0]};
        slot_v[0]       = s0.emit;
        st_next.counter = s0.counter;
        if (s0.need != NEED_NONE) begin
          st_next.hb[0]  = item.data_byte;
          st_next.held   = 2'd1;
          st_next.needed = s0.need;
        end
      end
      NEED_ONE: begin
        slot[0]        = '{cp: assemble(st, item.data_byte), glyph: st.counter[15:0]};
        slot_v[0]      = 1'b1;
        st_next.needed = NEED_NONE;
        st_next.held   = 2'd0;
      end
      default: begin
        // still collecting: store the continuation byte
        if (st.held == 2'd1) begin
          st_next.hb[1] = item.data_byte;
        end else begin
          st_next.hb[2] = item.data_byte;
        end
        st_next.held   = st.held + 2'd1;
        st_next.needed = st.needed - 2'd1;
        // truncated sequence: replacement for the lead, then replay the bytes after it
        if (item.end_of_table) begin
          slot_v[0] = 1'b1;
          if (st.held == 2'd1) begin
            slot[1]   = '{cp: s1b.cp, glyph: st.counter[15:0]};
            slot_v[1] = s1b.emit;
          end else begin
            slot[1]   = '{cp: s1.cp, glyph: st.counter[15:0]};
            slot_v[1] = s1.emit;
            if (s1.need == NEED_ONE) begin
              slot[2]   = '{cp: {10'd0, st.hb[1][4:0], item.data_byte[5:0]},
                            glyph: s1.counter[15:0]};
              slot_v[2] = 1'b1;
            end else if (s1.need != NEED_NONE) begin
              slot[2]   = '{cp: CP_REPLACE, glyph: s1.counter[15:0]};
              slot_v[2] = 1'b1;
              slot[3]   = '{cp: s2.cp, glyph: s1.counter[15:0]};
              slot_v[3] = s2.emit;
            end else begin
              slot[2]   = '{cp: s2.cp, glyph: s1.counter[15:0]};
              slot_v[2] = s2.emit;
            end
          end
        end
      end
    endcase
    // table end: close any sequence and restart the glyph count
    if (item.end_of_table) begin
      st_next.needed  = NEED_NONE;
      st_next.held    = 2'd0;
      st_next.counter = 17'd0;
    end
  end

  // Pack the valid results to the front, in order
  always_comb begin
    n   = 3'd0;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      if (slot_v[i]) begin
        res[n[1:0]] = slot[i];
        n = n + 3'd1;
      end
    end
    res_cnt = n;
  end

endmodule

/* rtl/psf2_unicode_table_parser.sv */
// PSF2 unicode table parser: byte stage, decode step and result buffer.
// An accepted byte is registered in the byte stage and decoded when the stage fires; its results
// are registered into the result buffer. Throughput: one byte per cycle while each byte yields at
// most one result and entry_stall is low; more results hold the byte stage as the port drains them.
// Reset: no open sequence, glyph counter 0, result buffer empty, glyph_total 256.
module psf2_unicode_table_parser
  import psf2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  item_t       byte_item,
  output logic        entry_valid,
  input  logic        entry_stall,
  output entry_t      entry_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  logic        stg_valid;
  item_t       stg_item;
  logic [16:0] glyph_total;
  st_t         st;
  st_t         st_next;
  res_t [3:0]  res;
  logic [2:0]  res_cnt;
  res_t [3:0]  ent;
  logic [2:0]  cnt;
  logic        byte_acc;
  logic        entry_acc;
  logic        fire;

  // Handshakes
  assign cfg_ready   = 1'b1;
  assign entry_valid = (cnt != 3'd0);
  assign entry_acc   = entry_valid && !entry_stall;
  assign fire        = stg_valid && ((cnt == 3'd0) || ((cnt == 3'd1) && entry_acc));
  assign byte_stall  = stg_valid && !fire;
  assign byte_acc    = byte_valid && !byte_stall;

  // Glyph limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_total <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      glyph_total <= cfg_data;
    end
  end

  // Byte stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (byte_acc) begin
      stg_valid <= 1'b1;
    end else if (fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      stg_item <= byte_item;
    end
  end

  psf2u_decode u_decode (
    .st          (st),
    .glyph_total (glyph_total),
    .item        (stg_item),
    .st_next     (st_next),
    .res         (res),
    .res_cnt     (res_cnt)
  );

  // Decoder state; held bytes carry no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      st.needed  <= NEED_NONE;
      st.held    <= 2'd0;
      st.counter <= 17'd0;
    end else if (fire) begin
      st.needed  <= st_next.needed;
      st.held    <= st_next.held;
      st.counter <= st_next.counter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && fire) begin
      st.hb <= st_next.hb;
    end
  end

  // Result buffer: one item's results, shifted out from the front
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (fire) begin
      cnt <= res_cnt;
    end else if (entry_acc) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ent <= res;
    end else if (entry_acc) begin
      ent[0] <= ent[1];
      ent[1] <= ent[2];
      ent[2] <= ent[3];
    end
  end

  assign entry_item = '{code_point:   ent[0].cp,
                        glyph_number: ent[0].glyph,
                        run_last:     (cnt == 3'd1)};

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result buffer count out of range");

  a_closed_seq: assert property (@(posedge clk) disable iff (rst)
    (st.needed == NEED_NONE) |-> (st.held == 2'd0))
    else $error("bytes held with no open sequence");

  a_table_end: assert property (@(posedge clk) disable iff (rst)
    (fire && stg_item.end_of_table) |=> (st.counter == 17'd0 && st.needed == NEED_NONE))
    else $error("table end did not reset decoder state");

endmodule

/* dv/psf2_entry_checker.sv */
// Result checker for the PSF2 unicode table parser: mirrors the byte decode and checks each result.
module psf2_entry_checker
  import psf2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  item_t       byte_item,
  input  logic        entry_valid,
  input  logic        entry_stall,
  input  entry_t      entry_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output int          error_count,
  output int          backlog
);

  // Mirror of the decoder state and the glyph_total register
  logic [7:0]  seq_bytes [3];
  logic [1:0]  cont_missing;
  logic [1:0]  held_count;
  logic [16:0] glyph_idx;
  logic [16:0] glyph_limit;

  entry_t expected_entries[$];
  entry_t got;
  entry_t want;

  function automatic void add_entry(input logic [20:0] cp);
    entry_t e;
    e.code_point   = cp;
    e.glyph_number = glyph_idx[15:0];
    e.run_last     = 1'b0;
    expected_entries.push_back(e);
  endfunction

  function automatic void close_seq();
    cont_missing = NEED_NONE;
    held_count   = 2'd0;
  endfunction

  function automatic void flag_mismatch(input string field, input logic [20:0] exp_val,
                                        input logic [20:0] act_val);
    error_count++;
    $display("%0t: %s expected %h, got %h", $time, field, exp_val, act_val);
  endfunction

  // Decode one table byte; a truncated sequence replays its held continuation bytes
  function automatic void decode_table_byte(input item_t it);
    logic [7:0]  replay [4];
    int          n_replay;
    int          k;
    int          first;
    logic [7:0]  b;
    logic        fin;
    logic [1:0]  lead_need;
    logic [20:0] cp;
    first    = expected_entries.size();
    replay[0] = it.data_byte;
    n_replay = 1;
    k        = 0;
    while (k < n_replay) begin
      b   = replay[k];
      fin = it.end_of_table && (k + 1 == n_replay);
      k++;
      if (cont_missing == NEED_NONE) begin
        // sequence start: glyph limit gates everything
        if (glyph_idx < glyph_limit) begin
          if (b == BYTE_GLYPH_SEP) begin
            glyph_idx = glyph_idx + 17'd1;
          end else if (b != BYTE_SEQ_SEP) begin
            if (!b[7]) begin
              add_entry({13'd0, b});
            end else begin
              if ((b & MASK_LEAD2) == PFX_LEAD2) lead_need = NEED_ONE;
              else if ((b & MASK_LEAD3) == PFX_LEAD3) lead_need = NEED_TWO;
              else if ((b & MASK_LEAD4) == PFX_LEAD4) lead_need = NEED_THREE;
              else lead_need = NEED_NONE;
              if (lead_need == NEED_NONE || fin) begin
                add_entry(CP_REPLACE);
              end else begin
                seq_bytes[0] = b;
                held_count   = 2'd1;
                cont_missing = lead_need;
              end
            end
          end
        end
      end else if (cont_missing == NEED_ONE) begin
        // last continuation: assemble the code point
        case (held_count)
          2'd1:    cp = {16'd0, seq_bytes[0][4:0]};
          2'd2:    cp = {17'd0, seq_bytes[0][3:0]};
          default: cp = {18'd0, seq_bytes[0][2:0]};
        endcase
        for (int i = 1; i < held_count; i++)
          cp = {cp[14:0], seq_bytes[i][5:0]};
        cp = {cp[14:0], b[5:0]};
        close_seq();
        add_entry(cp);
      end else begin
        seq_bytes[held_count] = b;
        held_count   = held_count + 2'd1;
        cont_missing = cont_missing - 2'd1;
        if (fin) begin
          // table ends mid-sequence: lead gives a replacement, the rest start over
          add_entry(CP_REPLACE);
          n_replay = 0;
          for (int i = 1; i < held_count; i++) begin
            replay[n_replay] = seq_bytes[i];
            n_replay++;
          end
          k = 0;
          close_seq();
        end
      end
    end
    if (it.end_of_table) begin
      close_seq();
      glyph_idx = '0;
    end
    if (expected_entries.size() > first)
      expected_entries[expected_entries.size() - 1].run_last = 1'b1;
  endfunction

  // Channel monitor: config, then input items, then results
  always @(posedge clk) begin
    if (rst) begin
      seq_bytes[0] = '0;
      seq_bytes[1] = '0;
      seq_bytes[2] = '0;
      close_seq();
      glyph_idx   = '0;
      glyph_limit = TOTAL_RESET;
      expected_entries.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        glyph_limit = cfg_data;
      if (byte_valid && !byte_stall)
        decode_table_byte(byte_item);
      if (entry_valid && !entry_stall) begin
        got = entry_item;
        if (expected_entries.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, got %h", $time, got);
        end else begin
          want = expected_entries.pop_front();
          if (got.code_point != want.code_point)
            flag_mismatch("code_point", want.code_point, got.code_point);
          if (got.glyph_number != want.glyph_number)
            flag_mismatch("glyph_number", 21'(want.glyph_number), 21'(got.glyph_number));
          if (got.run_last != want.run_last)
            flag_mismatch("run_last", 21'(want.run_last), 21'(got.run_last));
        end
      end
    end
    backlog <= expected_entries.size();
  end

endmodule

/* dv/psf2_unicode_table_parser_test.sv */
// Testbench top for the PSF2 unicode table parser: stimulus, result sink, watchdog and verdict.
module psf2_unicode_table_parser_test
  import psf2u_pkg::*;
();

  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 48;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  item_t       byte_item;
  logic        entry_valid;
  logic        entry_stall;
  entry_t      entry_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  int fail_count;
  int backlog;
  bit no_idle;
  bit hold_request;

  logic [7:0] table_bytes[$];

  psf2_unicode_table_parser DUT (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .entry_valid (entry_valid),
    .entry_stall (entry_stall),
    .entry_item  (entry_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  psf2_entry_checker entry_check (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .entry_valid (entry_valid),
    .entry_stall (entry_stall),
    .entry_item  (entry_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .error_count (fail_count),
    .backlog     (backlog)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic push_byte(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Send the queued table; the last byte carries end_of_table
  task automatic send_table_bytes();
    item_t it;
    for (int i = 0; i < table_bytes.size(); i++) begin
      it.data_byte    = table_bytes[i];
      it.end_of_table = (i == table_bytes.size() - 1);
      push_byte(it);
    end
  endtask

  // Stop sending, wait for every expected result, then let byte-only work finish
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One UTF-8 character; cut_short drops at least one continuation byte
  function automatic void add_char(input bit cut_short);
    logic [31:0] r;
    int          len;
    int          conts;
    r   = $urandom();
    len = $urandom_range(cut_short ? 2 : 1, 4);
    case (len)
      1:       table_bytes.push_back({1'b0, r[6:0]});
      2:       table_bytes.push_back({3'b110, r[4:0]});
      3:       table_bytes.push_back({4'b1110, r[3:0]});
      default: table_bytes.push_back({5'b11110, r[2:0]});
    endcase
    conts = len - 1;
    if (cut_short)
      conts = $urandom_range(0, len - 2);
    for (int i = 0; i < conts; i++) begin
      r = $urandom();
      // continuation bytes are unchecked, so sometimes send any byte
      if (r[31:29] == 3'd0) table_bytes.push_back(r[7:0]);
      else table_bytes.push_back({2'b10, r[5:0]});
    end
  endfunction

  // Mostly well-formed glyph entries with some noise and an occasional cut-off end
  function automatic void build_table();
    int glyphs;
    int chars;
    int roll;
    table_bytes.delete();
    glyphs = $urandom_range(1, 6);
    for (int g = 0; g < glyphs; g++) begin
      chars = $urandom_range(1, 3);
      for (int c = 0; c < chars; c++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) table_bytes.push_back(8'($urandom_range(0, 255)));
        else if (roll < 16) table_bytes.push_back(BYTE_SEQ_SEP);
        else add_char(1'b0);
      end
      if ($urandom_range(0, 9) != 0) table_bytes.push_back(BYTE_GLYPH_SEP);
    end
    roll = $urandom_range(0, 3);
    if (roll == 0) add_char(1'b1);
    else if (roll == 1) add_char(1'b0);
  endfunction

  // Result sink: random stall before each item, plus one long hold on request
  initial begin
    int gap;
    entry_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        entry_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        entry_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      entry_stall <= 1'b0;
      @(posedge clk);
      while (!entry_valid) @(posedge clk);
    end
  end

  // Watchdog: too long without any handshake ends the run
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && !byte_stall) || (entry_valid && !entry_stall) ||
          (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin
    logic [16:0] limits [7];
    int          phase_bytes;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_item  <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset glyph_total: ASCII ends, separators, every sequence length,
    // stray bytes, largest code point
    table_bytes = '{8'h00, 8'h7F, BYTE_SEQ_SEP, BYTE_GLYPH_SEP, 8'hC2, 8'hA9,
                    8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hF8,
                    8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_table_bytes();
    // table ends inside a three-byte sequence: held byte is replayed
    table_bytes = '{8'hE2, 8'h82};
    send_table_bytes();
    // lead byte as the very last byte
    table_bytes = '{8'hC3};
    send_table_bytes();
    // cut four-byte sequence whose replay decodes a full character
    table_bytes = '{8'hF0, 8'hC3, 8'hA9};
    send_table_bytes();

    // glyph_total of zero: everything at a sequence start is dropped
    drain();
    write_total(17'd0);
    build_table();
    send_table_bytes();

    // Random phases over a range of glyph limits
    limits = '{17'd1, 17'd65536, 17'd3, 17'($urandom_range(1, 20)), 17'h1FFFF,
               17'($urandom_range(0, 131071)), 17'd2};
    foreach (limits[p]) begin
      drain();
      write_total(limits[p]);
      no_idle = (p == 1 || p == 4);
      // back up the result path while bytes keep coming
      if (p == 4) hold_request = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_table();
        send_table_bytes();
        phase_bytes += table_bytes.size();
      end
    end
    no_idle = 1'b0;

    drain();
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/psf2u_pkg.sv
rtl/psf2u_decode.sv
rtl/psf2_unicode_table_parser.sv
dv/psf2_entry_checker.sv
dv/psf2_unicode_table_parser_test.sv
